// File: hw/rtl/xrr_pkg.sv
package xrr_pkg;

    localparam int WORD_W      = 32;
    localparam int SEED_COUNT  = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int DIV_COUNT_W = $clog2(WORD_W);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_ZERO  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_ONE   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_TWO   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_THREE = CFG_INDEX_W'(3);

    // seed register reset values
    localparam logic [WORD_W-1:0] SEED_ZERO_RST  = WORD_W'(1);
    localparam logic [WORD_W-1:0] SEED_ONE_RST   = WORD_W'(0);
    localparam logic [WORD_W-1:0] SEED_TWO_RST   = WORD_W'(0);
    localparam logic [WORD_W-1:0] SEED_THREE_RST = WORD_W'(0);

    // xoshiro128** shift and rotate amounts
    localparam int ROT_SCRAMBLE = 7;
    localparam int SHIFT_UPDATE = 9;
    localparam int ROT_UPDATE   = 11;

    typedef struct packed {
        logic                     mode;
        logic signed [WORD_W-1:0] range_begin;
        logic signed [WORD_W-1:0] range_end;
    } xrr_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] random_value;
        logic              range_error;
    } xrr_out_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } xrr_div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } xrr_div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WRITE
    } xrr_state_t;

endpackage

// File: hw/rtl/xoshiro128_range_random_top.sv
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-----------------------------------
// in       | input     | in_valid / in_stall   | in_data: mode, range_begin, range_end
// out      | output    | out_valid / out_stall | out_data: random_value, range_error
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (seed words)
//
// raw mode and empty ranges: accept, then result write, with no divide step
// ranged mode: accept, divide in the bit-serial remainder unit (one bit per cycle), then result write
// reset loads seeds {1, 0, 0, 0} into the generator; no clearing pass
// one item at a time; in_stall stays high from accept until the result is in the
// output register, and a stalled output only holds the block in its write state
module xoshiro128_range_random_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  xrr_pkg::xrr_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output xrr_pkg::xrr_out_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [xrr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [xrr_pkg::WORD_W-1:0]      cfg_data
);
    import xrr_pkg::*;

    xrr_state_t   state_reg, state_next;
    xrr_div_req_t div_req;
    xrr_div_rsp_t div_rsp;

    logic              accept;
    logic              cfg_write;
    logic              ranged;
    logic              empty;
    logic              out_free;
    logic              out_load;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] span;

    // result held between the sequencer and the output register
    logic [WORD_W-1:0] begin_reg, begin_next;
    xrr_out_t          result_reg, result_next;
    logic              out_valid_reg, out_valid_next;
    xrr_out_t          out_data_reg, out_data_next;

    // generator state and scrambler
    xrr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .word      (word)
    );

    // remainder unit for ranged mode
    xrr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // signed compare of the bounds, span taken unsigned
    assign empty    = (in_data.range_end <= in_data.range_begin);
    assign span     = WORD_W'(in_data.range_end) - WORD_W'(in_data.range_begin);
    assign ranged   = in_data.mode && !empty;
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ranged ? ST_DIVIDE : ST_WRITE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
            end
            ST_DIVIDE:
            begin
                in_stall = 1'b1;
            end
            ST_WRITE:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        accept           = in_valid && !in_stall;
        cfg_write        = cfg_valid && cfg_ready;
        div_req.start    = accept && ranged;
        div_req.dividend = word;
        div_req.divisor  = span;
    end

    // result capture: raw word, begin on an empty range, or remainder plus begin
    always_comb
    begin
        begin_next  = begin_reg;
        result_next = result_reg;
        if (accept)
        begin
            begin_next = WORD_W'(in_data.range_begin);
            if (!in_data.mode)
            begin
                result_next.random_value = word;
                result_next.range_error  = 1'b0;
            end
            else
            begin
                result_next.random_value = WORD_W'(in_data.range_begin);
                result_next.range_error  = empty;
            end
        end
        else if (div_rsp.done)
        begin
            result_next.random_value = div_rsp.remainder + begin_reg;
            result_next.range_error  = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        begin_reg    <= begin_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/xrr_core.sv
module xrr_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [xrr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [xrr_pkg::WORD_W-1:0]       cfg_data,
    input  logic                             advance,
    output logic [xrr_pkg::WORD_W-1:0]       word
);
    import xrr_pkg::*;

    logic [WORD_W-1:0] seed_reg  [SEED_COUNT];
    logic [WORD_W-1:0] seed_next [SEED_COUNT];
    logic [WORD_W-1:0] state_reg  [SEED_COUNT];
    logic [WORD_W-1:0] state_next [SEED_COUNT];
    logic              seed_hit;

    logic [WORD_W-1:0] mul5;
    logic [WORD_W-1:0] rot7;
    logic [WORD_W-1:0] s0_x, s1_x, s2_x, s3_x;

    // scrambler: rotl(s1 * 5, 7) * 9 as shift-adds
    always_comb
    begin
        mul5 = state_reg[1] + (state_reg[1] << 2);
        rot7 = {mul5[WORD_W-ROT_SCRAMBLE-1:0], mul5[WORD_W-1:WORD_W-ROT_SCRAMBLE]};
        word = rot7 + (rot7 << 3);
    end

    // seed register writes
    always_comb
    begin
        seed_next = seed_reg;
        seed_hit  = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SEED_ZERO:
                begin
                    seed_next[0] = cfg_data;
                    seed_hit     = 1'b1;
                end
                CFG_SEED_ONE:
                begin
                    seed_next[1] = cfg_data;
                    seed_hit     = 1'b1;
                end
                CFG_SEED_TWO:
                begin
                    seed_next[2] = cfg_data;
                    seed_hit     = 1'b1;
                end
                CFG_SEED_THREE:
                begin
                    seed_next[3] = cfg_data;
                    seed_hit     = 1'b1;
                end
                default:
                begin
                    seed_hit = 1'b0;
                end
            endcase
        end
    end

    // state update
    always_comb
    begin
        s2_x = state_reg[2] ^ state_reg[0];
        s3_x = state_reg[3] ^ state_reg[1];
        s1_x = state_reg[1] ^ s2_x;
        s0_x = state_reg[0] ^ s3_x;
        state_next = state_reg;
        if (seed_hit)
        begin
            state_next = seed_next;
        end
        else if (advance)
        begin
            state_next[0] = s0_x;
            state_next[1] = s1_x;
            state_next[2] = s2_x ^ (state_reg[1] << SHIFT_UPDATE);
            state_next[3] = {s3_x[WORD_W-ROT_UPDATE-1:0], s3_x[WORD_W-1:WORD_W-ROT_UPDATE]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg[0]  <= SEED_ZERO_RST;
            seed_reg[1]  <= SEED_ONE_RST;
            seed_reg[2]  <= SEED_TWO_RST;
            seed_reg[3]  <= SEED_THREE_RST;
            state_reg[0] <= SEED_ZERO_RST;
            state_reg[1] <= SEED_ONE_RST;
            state_reg[2] <= SEED_TWO_RST;
            state_reg[3] <= SEED_THREE_RST;
        end
        else
        begin
            seed_reg  <= seed_next;
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/xrr_divider.sv
module xrr_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xrr_pkg::xrr_div_req_t req,
    output xrr_pkg::xrr_div_rsp_t rsp
);
    import xrr_pkg::*;

    localparam logic [DIV_COUNT_W-1:0] DIV_LAST = DIV_COUNT_W'(WORD_W - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_COUNT_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]      rem_reg, rem_next;
    logic [WORD_W-1:0]      dvd_reg, dvd_next;
    logic [WORD_W-1:0]      dvs_reg, dvs_next;
    logic [WORD_W:0]        trial;
    logic [WORD_W:0]        diff;

    // one restoring step per cycle, msb first
    always_comb
    begin
        trial      = {rem_reg, dvd_reg[WORD_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            dvd_next   = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            dvd_next   = {dvd_reg[WORD_W-2:0], 1'b0};
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule
